### hdl/ovlpc_pkg.sv
// shared types and constants for the oid view longest prefix checker
// used by ovlpc_cell and oid_view_longest_prefix_check; no dependencies

package ovlpc_pkg;

	// default sizes of the subtree table
	localparam int ENTRIES_DEF  = 16;
	localparam int SUBIDS_DEF   = 32;
	localparam int NAME_MAX_DEF = 128;

	// field widths
	localparam int SLOT_W = 4;
	localparam int POS_W  = 5;
	localparam int SUB_W  = 32;
	localparam int VIEW_W = 16;
	localparam int LEN_W  = 6;
	localparam int CNT_W  = 8;

	// stream bus widths
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;

	// request kinds carried on tuser
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// one request as it travels down the cell row
	typedef struct packed {
		logic              is_query;
		logic              last;
		logic              ld_ok;     // slot and length in range
		logic              wr_ok;     // position inside the subtree store
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  position;
		logic [SUB_W-1:0]  sub_id;
		logic [VIEW_W-1:0] view;
		logic [LEN_W-1:0]  length;
		logic              active;
		logic              included;
		logic [CNT_W-1:0]  pos;       // name component index
		logic              cmp_en;    // name count not saturated
		logic [CNT_W-1:0]  name_len;  // name length after this component
	} req_t;

	// best match gathered so far along the row
	typedef struct packed {
		logic             found;
		logic [LEN_W-1:0] len;
		logic             incl;
	} best_t;

	// what one cell hands to its neighbor
	typedef struct packed {
		logic  vld;
		req_t  req;
		best_t best;
	} link_t;

endpackage

### hdl/ovlpc_ram.sv
// generic single write port ram with registered read
// no dependencies

module ovlpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/ovlpc_cell.sv
// one table entry cell: subtree words, entry flags and mismatch tracking
// depends on ovlpc_pkg and ovlpc_ram

module ovlpc_cell #(
	parameter int INDEX  = 0,
	parameter int SUBIDS = ovlpc_pkg::SUBIDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ovlpc_pkg::link_t  link_in,
	output ovlpc_pkg::link_t  link_out
);

	localparam int AW = (SUBIDS > 1) ? $clog2(SUBIDS) : 1;

	logic                        vld_s1, vld_s2;
	ovlpc_pkg::req_t             req_s1, req_s2;
	ovlpc_pkg::best_t            best_s1, best_s2;

	logic [ovlpc_pkg::LEN_W-1:0]  len_q;
	logic [ovlpc_pkg::VIEW_W-1:0] view_q;
	logic                         active_q;
	logic                         incl_q;
	logic                         mis_q;

	logic [ovlpc_pkg::SUB_W-1:0]  rdata;
	logic                         load_hit;
	logic                         ram_we;
	logic                         is_q;
	logic                         cur_mis;
	logic                         mis_all;
	logic                         hit;
	logic                         take;

	// load for this entry sits in the first stage
	assign load_hit = vld_s1 && !req_s1.is_query && req_s1.ld_ok &&
		(9'(req_s1.slot) == 9'(INDEX));
	assign ram_we   = adv && load_hit && req_s1.wr_ok;

	ovlpc_ram #(
		.WIDTH (ovlpc_pkg::SUB_W),
		.DEPTH (SUBIDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(req_s1.position)),
		.wdata (req_s1.sub_id),
		.re    (adv),
		.raddr (AW'(req_s1.pos)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= link_in.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1  <= link_in.req;
			best_s1 <= link_in.best;
			req_s2  <= req_s1;
			best_s2 <= best_s1;
		end
	end

	// second stage: compare component, then fold into best match
	always_comb begin
		is_q    = vld_s2 && req_s2.is_query;
		cur_mis = is_q && req_s2.cmp_en &&
			(req_s2.pos < ovlpc_pkg::CNT_W'(len_q)) && (rdata != req_s2.sub_id);
		mis_all = mis_q || cur_mis;
		hit     = active_q && (view_q == req_s2.view) && !mis_all &&
			(ovlpc_pkg::CNT_W'(len_q) <= req_s2.name_len);
		take    = is_q && req_s2.last && hit &&
			(!best_s2.found || (len_q > best_s2.len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			view_q   <= '0;
			active_q <= 1'b0;
			incl_q   <= 1'b0;
			mis_q    <= 1'b0;
		end else if (adv) begin
			if (load_hit) begin
				len_q    <= req_s1.length;
				view_q   <= req_s1.view;
				active_q <= req_s1.active;
				incl_q   <= req_s1.included;
			end
			if (is_q) begin
				mis_q <= req_s2.last ? 1'b0 : mis_all;
			end
		end
	end

	always_comb begin
		link_out.vld = vld_s2;
		link_out.req = req_s2;
		if (take) begin
			link_out.best.found = 1'b1;
			link_out.best.len   = len_q;
			link_out.best.incl  = incl_q;
		end else begin
			link_out.best = best_s2;
		end
	end

endmodule

### hdl/oid_view_longest_prefix_check.sv
// top level of the oid view longest prefix checker: name counter, cell row, result register
// depends on ovlpc_pkg, ovlpc_cell and ovlpc_ram

// channel  | dir | fields
// s_axis   | in  | tdata: slot, position, sub_id, view_number, subtree_length,
//          |     |        entry_active, entry_included; tuser: mode; tlast: last
// m_axis   | out | tdata: permitted, matched, match_length
//
// one request is taken per cycle unless the row is stalled; every request walks the row of
// ENTRIES cells, two register stages per cell, and the result of a last query component
// then waits in the result register until it is taken
// the single result register sets the stall: while it holds an untaken result
// the whole row and the input freeze
// reset clears the entry flags, lengths, views, mismatch flags and name count;
// the subtree words stay undefined until loaded, there is no clearing pass

module oid_view_longest_prefix_check #(
	parameter int ENTRIES  = ovlpc_pkg::ENTRIES_DEF,
	parameter int SUBIDS   = ovlpc_pkg::SUBIDS_DEF,
	parameter int NAME_MAX = ovlpc_pkg::NAME_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slot[3:0], position[8:4], sub_id[40:9], view_number[56:41],
	// subtree_length[62:57], entry_active[63], entry_included[64], zero[71:65]
	input  logic [ovlpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode[0]
	input  logic [0:0]                       s_axis_tuser,
	input  logic                             s_axis_tlast,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// permitted[0], matched[1], match_length[7:2]
	output logic [ovlpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready
);

	logic                         adv;
	logic                         acc;
	logic [ovlpc_pkg::CNT_W-1:0]  cnt_q;
	logic                         cmp_en;
	logic [ovlpc_pkg::CNT_W-1:0]  cnt_next;
	ovlpc_pkg::link_t             links [ENTRIES+1];
	ovlpc_pkg::req_t              head_req;
	logic                         res_q;
	ovlpc_pkg::best_t             best_q;

	// row moves whenever the result register is free or being emptied
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;

	// name counter saturates, later components are not compared
	assign cmp_en   = cnt_q < ovlpc_pkg::CNT_W'(NAME_MAX);
	assign cnt_next = cmp_en ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc && (s_axis_tuser[0] == ovlpc_pkg::MODE_QUERY)) begin
			cnt_q <= s_axis_tlast ? '0 : cnt_next;
		end
	end

	// unpack the request and check load ranges once at the head
	always_comb begin
		head_req.is_query = (s_axis_tuser[0] == ovlpc_pkg::MODE_QUERY);
		head_req.last     = s_axis_tlast;
		head_req.slot     = s_axis_tdata[3:0];
		head_req.position = s_axis_tdata[8:4];
		head_req.sub_id   = s_axis_tdata[40:9];
		head_req.view     = s_axis_tdata[56:41];
		head_req.length   = s_axis_tdata[62:57];
		head_req.active   = s_axis_tdata[63];
		head_req.included = s_axis_tdata[64];
		// loads with a slot past the table or an overlong subtree are dropped
		head_req.ld_ok    = (9'(head_req.slot) < 9'(ENTRIES)) &&
			(7'(head_req.length) <= 7'(SUBIDS));
		// position past the store still updates the entry fields
		head_req.wr_ok    = 7'(head_req.position) < 7'(SUBIDS);
		head_req.pos      = cnt_q;
		head_req.cmp_en   = cmp_en;
		head_req.name_len = cnt_next;
	end

	always_comb begin
		links[0].vld  = acc;
		links[0].req  = head_req;
		links[0].best = '0;
	end

	// one cell per table entry, lowest entry first so ties keep the lowest
	for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
		ovlpc_cell #(
			.INDEX  (e),
			.SUBIDS (SUBIDS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.link_in  (links[e]),
			.link_out (links[e+1])
		);
	end

	// result register: only a last query component yields a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= 1'b0;
		end else if (adv) begin
			res_q <= links[ENTRIES].vld && links[ENTRIES].req.is_query &&
				links[ENTRIES].req.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			best_q <= links[ENTRIES].best;
		end
	end

	assign m_axis_tvalid = res_q;
	assign m_axis_tdata  = {best_q.len, best_q.found, best_q.found && best_q.incl};

	// no match must report a zero length and a denied name
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[7:2] == '0 && !m_axis_tdata[0])
		else $error("result without match carries length or permit");

	// name counter stays within its saturation limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ovlpc_pkg::CNT_W'(NAME_MAX))
		else $error("name count beyond limit");

	// a last query component restarts the name
	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser[0] == ovlpc_pkg::MODE_QUERY && s_axis_tlast |=> cnt_q == '0)
		else $error("name count not cleared after last component");

	// an unsaturated query component that is not the last advances the name count by one
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser[0] == ovlpc_pkg::MODE_QUERY && !s_axis_tlast && cmp_en
		|=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("name count did not advance");

	// a held result freezes the row
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(links[ENTRIES].vld) && m_axis_tvalid)
		else $error("row moved under a held result");

endmodule

### sim/oid_view_longest_prefix_check_tb.sv
// self-checking bench for oid_view_longest_prefix_check: a directed table, then random
// subtree loads and name queries, each verdict checked against its typed value or an in-bench predictor
// depends on ovlpc_pkg and the rtl under hdl
`timescale 1ns / 100ps

module oid_view_longest_prefix_check_tb;

	localparam int ENTRIES     = ovlpc_pkg::ENTRIES_DEF;
	localparam int SUBIDS      = ovlpc_pkg::SUBIDS_DEF;
	localparam int NAME_MAX    = ovlpc_pkg::NAME_MAX_DEF;
	localparam int LATENCY     = 2 * ENTRIES + 1;
	localparam int ITEMS       = 2000;
	localparam int QUIET_ITEMS = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;
	localparam int MAX_PRINTS  = 40;

	// one request as the bench sees it, fields at the block's widths
	typedef struct packed {
		logic                              mode;
		logic [ovlpc_pkg::SLOT_W-1:0]      slot;
		logic [ovlpc_pkg::POS_W-1:0]       position;
		logic [ovlpc_pkg::SUB_W-1:0]       sub_id;
		logic [ovlpc_pkg::VIEW_W-1:0]      view;
		logic [ovlpc_pkg::LEN_W-1:0]       length;
		logic                              active;
		logic                              included;
		logic                              last;
	} access_req_t;

	typedef struct packed {
		logic                         permitted;
		logic                         matched;
		logic [ovlpc_pkg::LEN_W-1:0]  match_length;
	} verdict_t;

	// a directed row either carries its verdict typed in or leaves it to the predictor
	typedef struct packed {
		access_req_t req;
		logic        typed;
		verdict_t    verdict;
	} dir_row_t;

	localparam logic     PREDICTED = 1'b0;
	localparam logic     TYPED     = 1'b1;
	localparam verdict_t DENIED    = '{1'b0, 1'b0, 6'd0};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic [ovlpc_pkg::IN_DATA_W-1:0]   s_axis_tdata;   // slot, position, sub_id, view,
	                                                   // length, active, included, zero
	logic [0:0]                        s_axis_tuser;   // mode
	logic                              s_axis_tlast;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [ovlpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;   // permitted, matched, match_length
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;

	// predictor copy of the subtree table; written flags keep queries off unloaded words
	logic [ovlpc_pkg::SUB_W-1:0]  subtree_word [ENTRIES][SUBIDS];
	bit                           word_written [ENTRIES][SUBIDS] = '{default: 1'b0};
	logic [ovlpc_pkg::LEN_W-1:0]  ent_len    [ENTRIES] = '{default: '0};
	logic [ovlpc_pkg::VIEW_W-1:0] ent_view   [ENTRIES] = '{default: '0};
	bit                           ent_active [ENTRIES] = '{default: 1'b0};
	bit                           ent_incl   [ENTRIES] = '{default: 1'b0};
	bit                           ent_miss   [ENTRIES] = '{default: 1'b0};
	int                           name_count = 0;

	verdict_t    awaited_verdicts [$];
	dir_row_t    dir_table [$];
	int          requests_sent  = 0;
	int          verdicts_seen  = 0;
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          quiet          = 1'b0;

	oid_view_longest_prefix_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	always #5 clk = ~clk;

	// runaway guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycle_count, awaited_verdicts.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t mismatch, %s: got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// steps the predicted table by one request; returns 1 when a verdict comes out
	function automatic bit predict_access_verdict(input access_req_t r, output verdict_t v);
		int best;
		bit found, incl;
		v = DENIED;
		if (r.mode == ovlpc_pkg::MODE_LOAD) begin
			// a row longer than the store cannot be created, nothing changes
			if (r.length > SUBIDS)
				return 1'b0;
			if (r.position < SUBIDS) begin
				subtree_word[r.slot][r.position] = r.sub_id;
				word_written[r.slot][r.position] = 1'b1;
			end
			ent_len[r.slot]    = r.length;
			ent_view[r.slot]   = r.view;
			ent_active[r.slot] = r.active;
			ent_incl[r.slot]   = r.included;
			return 1'b0;
		end
		// each entry compares this component; past the name limit nothing is compared
		if (name_count < NAME_MAX) begin
			for (int e = 0; e < ENTRIES; e++)
				if (name_count < ent_len[e] && name_count < SUBIDS &&
						subtree_word[e][name_count] != r.sub_id)
					ent_miss[e] = 1'b1;
			name_count++;
		end
		if (!r.last)
			return 1'b0;
		// longest clean active entry of the view wins, lowest slot on a tie
		found = 1'b0;
		incl  = 1'b0;
		best  = 0;
		for (int e = 0; e < ENTRIES; e++)
			if (ent_active[e] && ent_view[e] == r.view && !ent_miss[e] &&
					ent_len[e] <= name_count && (!found || ent_len[e] > best)) begin
				found = 1'b1;
				best  = int'(ent_len[e]);
				incl  = ent_incl[e];
			end
		v.permitted    = found && incl;
		v.matched      = found;
		v.match_length = 6'(best);
		name_count = 0;
		ent_miss   = '{default: 1'b0};
		return 1'b1;
	endfunction

	// tlast is meaningless on a load, so it is left random
	function automatic access_req_t load_req(int slot, int pos, logic [31:0] sub,
			logic [15:0] view, int len, bit act, bit incl);
		access_req_t r;
		r.mode     = ovlpc_pkg::MODE_LOAD;
		r.slot     = 4'(slot);
		r.position = 5'(pos);
		r.sub_id   = sub;
		r.view     = view;
		r.length   = 6'(len);
		r.active   = act;
		r.included = incl;
		r.last     = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// load-only fields ride along as noise on a query
	function automatic access_req_t query_req(logic [31:0] sub, logic [15:0] view, bit last);
		access_req_t r;
		r.mode     = ovlpc_pkg::MODE_QUERY;
		r.slot     = 4'($urandom);
		r.position = 5'($urandom);
		r.sub_id   = sub;
		r.view     = view;
		r.length   = 6'($urandom);
		r.active   = 1'($urandom_range(0, 1));
		r.included = 1'($urandom_range(0, 1));
		r.last     = last;
		return r;
	endfunction

	// views cluster on a few values so that entries and queries meet
	function automatic logic [15:0] pick_view();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] random_sub_id();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 3));
			1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	// loaded words from position 0 up, counting one about to be written
	function automatic int written_prefix(int slot, int extra);
		int n;
		n = 0;
		while (n < SUBIDS && (word_written[slot][n] || n == extra))
			n++;
		return n;
	endfunction

	// drives one request from the falling edge, holds it until taken, then predicts
	task automatic send_request(input access_req_t r, input logic typed, input verdict_t tv);
		int gap;
		verdict_t v;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tdata  <= {7'b0, r.included, r.active, r.length, r.view, r.sub_id,
			r.position, r.slot};
		s_axis_tuser  <= r.mode;
		s_axis_tlast  <= r.last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_access_verdict(r, v))
			awaited_verdicts.push_back(typed ? tv : v);
		requests_sent++;
	endtask

	// sender goes quiet until every awaited verdict is out
	task automatic wait_for_verdicts();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (awaited_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// stray load with random fields; a row it creates never reaches an unloaded word
	task automatic send_stray_load();
		access_req_t r;
		int room;
		r = load_req($urandom_range(0, ENTRIES - 1), $urandom_range(0, SUBIDS - 1),
			random_sub_id(), pick_view(), $urandom_range(0, 63),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if (r.length <= SUBIDS) begin
			room = written_prefix(int'(r.slot), int'(r.position));
			if (r.length > room)
				r.length = 6'($urandom_range(0, room));
		end
		send_request(r, PREDICTED, DENIED);
	endtask

	// results are taken on the rising edge and compared with the oldest prediction
	always @(posedge clk) begin : watch_results
		verdict_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			verdicts_seen++;
			got.permitted    = m_axis_tdata[0];
			got.matched      = m_axis_tdata[1];
			got.match_length = m_axis_tdata[7:2];
			if (awaited_verdicts.size() == 0) begin
				report_mismatch("result with none awaited", longint'(m_axis_tdata), -1);
			end else begin
				want = awaited_verdicts.pop_front();
				if (got.permitted != want.permitted)
					report_mismatch("permitted", longint'(got.permitted),
						longint'(want.permitted));
				if (got.matched != want.matched)
					report_mismatch("matched", longint'(got.matched),
						longint'(want.matched));
				if (got.match_length != want.match_length)
					report_mismatch("match_length", longint'(got.match_length),
						longint'(want.match_length));
			end
		end
	end

	// result side: short random stalls, one long hold-off once results flow,
	// always ready in the closing stretch
	initial begin : result_sink
		int  stall_left;
		bit  hold_done;
		stall_left    = 0;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && verdicts_seen >= 40) begin
				// long enough for the row to fill and push back on the input
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int          pick, slot, len, donor, shared, base, blen, n, flip, stray_at;
		int          long_names;
		logic [31:0] word;
		logic [15:0] view;
		bit          act, incl, paused;

		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		long_names    = 4;
		paused        = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// typed verdicts only where the table state is obvious
		dir_table = '{
			// nothing loaded yet, every name is denied
			'{query_req(32'h0, 16'h0000, 1'b1), TYPED, DENIED},
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1), TYPED, DENIED},
			// empty subtree in view 0 covers any name of that view
			'{load_req(0, 0, 32'h0, 16'h0000, 0, 1'b1, 1'b1), PREDICTED, DENIED},
			'{query_req(32'h5, 16'h0000, 1'b1), TYPED, '{1'b1, 1'b1, 6'd0}},
			'{query_req(32'h5, 16'h0001, 1'b1), TYPED, DENIED},
			// excluded one-word subtree at the top slot, all-ones everywhere
			'{load_req(15, 0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, 1'b0), PREDICTED, DENIED},
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1), TYPED, '{1'b0, 1'b1, 6'd1}},
			'{query_req(32'hFFFF_FFFE, 16'hFFFF, 1'b1), TYPED, DENIED},
			// same subtree included at slot 1, the lower slot wins the tie
			'{load_req(1, 0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, 1'b1), PREDICTED, DENIED},
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1), TYPED, '{1'b1, 1'b1, 6'd1}},
			// longer excluded subtree under it
			'{load_req(2, 0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, 1'b1), PREDICTED, DENIED},
			'{load_req(2, 1, 32'h1234_5678, 16'hFFFF, 2, 1'b1, 1'b0), PREDICTED, DENIED},
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b0), PREDICTED, DENIED},
			'{query_req(32'h1234_5678, 16'hFFFF, 1'b1), TYPED, '{1'b0, 1'b1, 6'd2}},
			// name shorter than the deeper subtree falls back to slot 1
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1), TYPED, '{1'b1, 1'b1, 6'd1}},
			// overlong row is refused, slot 1 keeps its contents
			'{load_req(1, 0, 32'h0, 16'h0000, 63, 1'b0, 1'b0), PREDICTED, DENIED},
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1), TYPED, '{1'b1, 1'b1, 6'd1}},
			// inactive entry drops out of the match
			'{load_req(1, 0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b0, 1'b1), PREDICTED, DENIED},
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1), TYPED, '{1'b0, 1'b1, 6'd1}},
			// reload in the middle of a name: later words compare with the new content
			'{query_req(32'hFFFF_FFFF, 16'hFFFF, 1'b0), PREDICTED, DENIED},
			'{load_req(2, 1, 32'h0, 16'hFFFF, 2, 1'b1, 1'b1), PREDICTED, DENIED},
			'{query_req(32'h0, 16'hFFFF, 1'b1), PREDICTED, DENIED}
		};
		foreach (dir_table[i])
			send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].verdict);
		wait_for_verdicts();

		while (requests_sent < ITEMS) begin
			quiet = (requests_sent >= ITEMS - QUIET_ITEMS);
			// one full pause halfway, until the pipeline is empty
			if (!paused && requests_sent >= ITEMS / 2) begin
				paused = 1'b1;
				wait_for_verdicts();
			end
			pick = $urandom_range(0, 99);
			if (pick < 14) begin
				// whole subtree loaded in order with its length growing word by word,
				// often sharing a head with another entry so that subtrees nest
				slot  = $urandom_range(0, ENTRIES - 1);
				len   = ($urandom_range(0, 5) == 0) ? SUBIDS : $urandom_range(0, 8);
				donor = $urandom_range(0, ENTRIES - 1);
				shared = $urandom_range(0, 1) ? written_prefix(donor, -1) : 0;
				view  = $urandom_range(0, 1) ? ent_view[donor] : pick_view();
				act   = ($urandom_range(0, 5) != 0);
				incl  = 1'($urandom_range(0, 1));
				if (len == 0)
					send_request(load_req(slot, $urandom_range(0, SUBIDS - 1),
						random_sub_id(), view, 0, act, incl), PREDICTED, DENIED);
				for (int p = 0; p < len; p++) begin
					word = (p < shared) ? subtree_word[donor][p] : random_sub_id();
					send_request(load_req(slot, p, word, view, p + 1, act, incl),
						PREDICTED, DENIED);
				end
			end else if (pick < 24) begin
				send_stray_load();
			end else begin
				// name built on a loaded subtree, sometimes longer, shorter or broken
				base = $urandom_range(0, ENTRIES - 1);
				blen = int'(ent_len[base]);
				if (long_names > 0 && $urandom_range(0, 49) == 0) begin
					// runs past the name limit so the counter saturates
					long_names--;
					n = $urandom_range(NAME_MAX + 1, NAME_MAX + 12);
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: n = blen + $urandom_range(0, 2);
						6, 7: n = $urandom_range(1, 6);
						8: n = blen - 1;
						default: n = $urandom_range(1, SUBIDS + 8);
					endcase
				end
				if (n < 1)
					n = 1;
				flip     = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
				stray_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
				view     = ($urandom_range(0, 4) != 0) ? ent_view[base] : pick_view();
				for (int i = 0; i < n; i++) begin
					if (i == stray_at)
						send_stray_load();
					word = (i < blen) ? subtree_word[base][i] : random_sub_id();
					if (i == flip)
						word ^= 32'h1 << $urandom_range(0, 31);
					// only the view on the closing component counts
					send_request(query_req(word, (i == n - 1) ? view : 16'($urandom),
						i == n - 1), PREDICTED, DENIED);
				end
			end
		end

		quiet = 1'b1;
		wait_for_verdicts();
		// anything arriving now is unexpected and gets flagged by the result watcher
		repeat (LATENCY + 8) @(posedge clk);
		if (awaited_verdicts.size() != 0)
			report_mismatch("results never delivered", longint'(awaited_verdicts.size()), 0);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### files.f
hdl/ovlpc_pkg.sv
hdl/ovlpc_ram.sv
hdl/ovlpc_cell.sv
hdl/oid_view_longest_prefix_check.sv
sim/oid_view_longest_prefix_check_tb.sv
